FILE: rtl/linear_interp_resampler_core_defines.svh
// Assertion macros shared by the checker of the resampler core.
// Depends on nothing; included by the files that hold assertions.
`ifndef LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LIR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("resampler check failed");

// Antecedent implies consequent in the following cycle.
`define LIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("resampler check failed");

`endif

FILE: rtl/lir_pkg.sv
// Shared types and constants of the linear interpolation resampler.
// Depends on nothing; used by every module of the block.
package lir_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int FRAC_W          = 16;
   localparam int CNT_W           = 7;
   localparam int IN_DEPTH_DEF    = 256;
   localparam int OUT_MAX_DEF     = 64;
   localparam logic [CNT_W-1:0] OUT_COUNT_RESET = 7'd64;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       last_out;
   } rsp_type;

endpackage

FILE: rtl/linear_interp_resampler_core.sv
// Top level of the linear interpolation resampler: sample store, sequencer and blend.
// Depends on lir_pkg and lir_divider.
//
//   channel   direction   payload                   flow control
//   req       in          sample, last_in           req_valid / req_stall
//   rsp       out         value, last_out           rsp_valid / rsp_stall
//   csr       in          out_count (7 bits)        csr_we, no read-back
//
// Loading accepts one request per cycle into the single sample memory.
// The request marked last then starts the step divider.
// Each result passes memory read, multiply and round, waiting in round on rsp stall.
// Reset is synchronous and clears the control state; the memory is not cleared.
// While the results of a vector are produced, req_stall stays high.
module linear_interp_resampler_core #(
   parameter int IN_DEPTH = lir_pkg::IN_DEPTH_DEF,
   parameter int OUT_MAX  = lir_pkg::OUT_MAX_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lir_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lir_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [lir_pkg::CNT_W-1:0] csr_wdata
);

   localparam int NW = $clog2(IN_DEPTH + 1);
   localparam int AW = $clog2(IN_DEPTH);
   localparam int QW = NW + lir_pkg::FRAC_W;
   localparam int SW = lir_pkg::SAMPLE_W;
   localparam int CW = lir_pkg::CNT_W;

   typedef enum logic [4:0] {
      ST_LOAD = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_READ = 5'b00100,
      ST_MULT = 5'b01000,
      ST_SUM  = 5'b10000
   } state_type;

   logic signed [SW-1:0] store [IN_DEPTH];

   state_type            state_ff, state_in;
   logic [CW-1:0]        out_count_ff;
   logic [NW-1:0]        count_ff, count_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [QW-1:0]        step_ff, step_in;
   logic [QW-1:0]        pos_ff, pos_in;
   logic [lir_pkg::FRAC_W-1:0] frac_ff;
   logic signed [SW-1:0] rd_l_ff, rd_r_ff;
   logic signed [SW-1:0] left_ff;
   logic signed [2*SW+1:0] prod_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lir_pkg::rsp_type     rsp_ff, rsp_in;

   logic                 req_take;
   logic                 room;
   logic                 div_start;
   logic                 div_done;
   logic [QW-1:0]        div_quo;
   logic [CW-1:0]        cnt_sat;
   logic [NW-1:0]        idx, nm1;
   logic [NW:0]          idx1;
   logic [NW-1:0]        li, ri;
   logic signed [SW:0]   diff;
   logic signed [2*SW+2:0] acc;
   logic signed [SW+2:0] rounded;
   logic signed [SW-1:0] sat_val;
   logic                 rsp_load;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign room      = (count_ff != NW'(IN_DEPTH));

   always_comb begin
      if (out_count_ff == '0) begin
         cnt_sat = CW'(1);
      end else if (out_count_ff > CW'(OUT_MAX)) begin
         cnt_sat = CW'(OUT_MAX);
      end else begin
         cnt_sat = out_count_ff;
      end
   end

   always_comb begin
      idx  = pos_ff[QW-1:lir_pkg::FRAC_W];
      nm1  = n_ff - 1'b1;
      idx1 = {1'b0, idx} + 1'b1;
      li   = (idx < nm1) ? idx : nm1;
      ri   = (idx1 < {1'b0, nm1}) ? idx1[NW-1:0] : nm1;
   end

   always_comb begin
      diff    = {rd_r_ff[SW-1], rd_r_ff} - {rd_l_ff[SW-1], rd_l_ff};
      acc     = {{3{left_ff[SW-1]}}, left_ff, {lir_pkg::FRAC_W{1'b0}}}
                + (2*SW+3)'(prod_ff) + (2*SW+3)'(32768);
      rounded = acc[2*SW+2:lir_pkg::FRAC_W];
      if (rounded > (SW+3)'(32767)) begin
         sat_val = SW'(32767);
      end else if (rounded < -(SW+3)'(32768)) begin
         sat_val = SW'(-32768);
      end else begin
         sat_val = rounded[SW-1:0];
      end
   end

   lir_divider #(
      .QW(QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({n_in, {lir_pkg::FRAC_W{1'b0}}}),
      .divisor  (cnt_in),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (room) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_data.last_in) begin
                  n_in      = room ? count_ff + 1'b1 : count_ff;
                  cnt_in    = cnt_sat;
                  count_in  = '0;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               step_in  = div_quo;
               pos_in   = '0;
               k_in     = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load        = 1'b1;
               rsp_in.value    = sat_val;
               rsp_in.last_out = (k_ff == cnt_ff - 1'b1);
               pos_in          = pos_ff + step_ff;
               k_in            = k_ff + 1'b1;
               state_in        = (k_ff == cnt_ff - 1'b1) ? ST_LOAD : ST_READ;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         out_count_ff <= lir_pkg::OUT_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            out_count_ff <= csr_wdata;
         end
      end
      n_ff    <= n_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      step_ff <= step_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (req_take && room) begin
         store[count_ff[AW-1:0]] <= req_data.sample;
      end
      rd_l_ff <= store[li[AW-1:0]];
      rd_r_ff <= store[ri[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         frac_ff <= pos_ff[lir_pkg::FRAC_W-1:0];
      end
      if (state_ff == ST_MULT) begin
         prod_ff <= diff * $signed({1'b0, frac_ff});
         left_ff <= rd_l_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/lir_divider.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on lir_pkg for the divisor width.
module lir_divider #(
   parameter int QW = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [QW-1:0]             dividend,
   input  logic [lir_pkg::CNT_W-1:0] divisor,
   output logic                      done,
   output logic [QW-1:0]             quotient
);

   localparam int IW = $clog2(QW + 1);

   logic [QW-1:0]               quo_ff, quo_in;
   logic [lir_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [IW-1:0]               iter_ff, iter_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [lir_pkg::CNT_W:0]     rem_sh;
   logic [lir_pkg::CNT_W:0]     rem_diff;
   logic                        fits;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[QW-1]};
      fits     = rem_sh >= {1'b0, divisor};
      rem_diff = rem_sh - {1'b0, divisor};
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      iter_in  = iter_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         iter_in = IW'(QW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[QW-2:0], fits};
         rem_in  = fits ? rem_diff[lir_pkg::CNT_W-1:0] : rem_sh[lir_pkg::CNT_W-1:0];
         iter_in = iter_ff - 1'b1;
         if (iter_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      iter_ff <= iter_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/lir_checker.sv
// Port-level checker for the resampler core, attached to it by a bind statement.
// Depends on lir_pkg and linear_interp_resampler_core_defines.svh.
`include "linear_interp_resampler_core_defines.svh"

module lir_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input lir_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lir_pkg::rsp_type rsp_data
);

   // A stalled result stays valid and unchanged.
   `LIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A request that ends a vector makes the block busy.
   `LIR_ASSERT_NEXT(a_last_busy, clock, reset, req_valid && !req_stall && req_data.last_in, req_stall)

   // A request inside a vector keeps the block loading.
   `LIR_ASSERT_NEXT(a_mid_load, clock, reset, req_valid && !req_stall && !req_data.last_in, !req_stall)

   // A result that is not the last of its run only appears while the block is busy.
   `LIR_ASSERT_SAME(a_mid_rsp, clock, reset, rsp_valid && !rsp_data.last_out, req_stall)

endmodule

bind linear_interp_resampler_core lir_checker u_lir_checker (.*);

FILE: dv/lir_resample_checker.sv
// Checker for the linear interpolation resampler core. It watches the request, result and
// csr ports, predicts every resampled value from the accepted requests and compares in order.
// Depends on lir_pkg.
module lir_resample_checker #(
   parameter int IN_DEPTH = lir_pkg::IN_DEPTH_DEF,
   parameter int OUT_MAX  = lir_pkg::OUT_MAX_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  lir_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  lir_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [lir_pkg::CNT_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending_count,
   output int                        checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lir_pkg::SAMPLE_W-1:0] OFFSET_BIN = 16'h8000;

   logic [lir_pkg::SAMPLE_W-1:0] sample_mem [IN_DEPTH];
   int unsigned                  samples_held = 0;
   logic [lir_pkg::CNT_W-1:0]    count_setting = lir_pkg::OUT_COUNT_RESET;
   lir_pkg::rsp_type             resampled_due [$];
   int                           errors = 0;
   int                           checked = 0;

   function automatic logic [lir_pkg::SAMPLE_W-1:0] blend(
         input logic [lir_pkg::SAMPLE_W-1:0] left, right,
         input logic [lir_pkg::FRAC_W-1:0] frac);
      logic [47:0] acc;
      logic [31:0] level;
      acc = 48'(left ^ OFFSET_BIN) * (48'd65536 - 48'(frac))
          + 48'(right ^ OFFSET_BIN) * 48'(frac) + 48'd32768;
      level = acc[47:16];
      if (level > 32'd65535) level = 32'd65535;
      return level[lir_pkg::SAMPLE_W-1:0] ^ OFFSET_BIN;
   endfunction

   function automatic void resample_vector();
      int unsigned      n, outs, step, pos, idx, li, ri, k;
      lir_pkg::rsp_type r;
      n = samples_held;
      outs = count_setting;
      if (outs == 0) outs = 1;
      if (outs > OUT_MAX) outs = OUT_MAX;
      step = (n << lir_pkg::FRAC_W) / outs;
      pos = 0;
      for (k = 0; k < outs; k++) begin
         idx = pos >> lir_pkg::FRAC_W;
         li = (idx < n - 1) ? idx : n - 1;
         ri = (idx + 1 < n - 1) ? idx + 1 : n - 1;
         r.value = blend(sample_mem[li], sample_mem[ri], pos[lir_pkg::FRAC_W-1:0]);
         r.last_out = (k + 1 == outs);
         resampled_due = {resampled_due, r};
         pos += step;
      end
      samples_held = 0;
   endfunction

   always @(posedge clock) begin : watch
      lir_pkg::rsp_type want;
      if (reset) begin
         resampled_due.delete();
         samples_held = 0;
         count_setting = lir_pkg::OUT_COUNT_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (resampled_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual value %0d last_out %0b",
                        $time, rsp_data.value, rsp_data.last_out);
            end else begin
               want = resampled_due.pop_front();
               checked++;
               if (rsp_data.value !== want.value) begin
                  errors++;
                  $display("%0t: value mismatch: expected %0d, actual %0d",
                           $time, want.value, rsp_data.value);
               end
               if (rsp_data.last_out !== want.last_out) begin
                  errors++;
                  $display("%0t: last_out mismatch: expected %0b, actual %0b",
                           $time, want.last_out, rsp_data.last_out);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (samples_held < IN_DEPTH) begin
               sample_mem[samples_held] = req_data.sample;
               samples_held++;
            end
            if (req_data.last_in) resample_vector();
         end
         if (csr_we) count_setting = csr_wdata;
      end
      fail_count <= errors;
      pending_count <= resampled_due.size();
      checked_count <= checked;
   end

endmodule

FILE: dv/tb_linear_interp_resampler_core.sv
// Top of the resampler testbench: clock, reset, request and csr stimulus, result stalls
// and the verdict. Depends on lir_pkg, linear_interp_resampler_core and lir_resample_checker.
module tb_linear_interp_resampler_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [lir_pkg::SAMPLE_W-1:0] sample_list_type [$];

   localparam int IDLE_LIMIT      = 4000;
   localparam int RANDOM_REQUESTS = 150;
   localparam int CALM_REQUESTS   = 30;
   localparam int TAIL_CYCLES     = 40;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   lir_pkg::req_type          req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   lir_pkg::rsp_type          rsp_data;
   logic                      csr_we = 1'b0;
   logic [lir_pkg::CNT_W-1:0] csr_wdata = '0;

   int              fail_count;
   int              pending_count;
   int              checked_count;
   int              requests_sent = 0;
   int              vectors_sent = 0;
   int              idle_cycles = 0;
   bit              calm_tail = 1'b0;
   sample_list_type vec;

   linear_interp_resampler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lir_resample_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [lir_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 8) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [lir_pkg::CNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd64;
         2: return 7'($urandom_range(65, 127));
         3: return 7'($urandom);
         default: return 7'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic int pick_length();
      case ($urandom_range(0, 9))
         7, 8: return $urandom_range(9, 40);
         9: return $urandom_range(41, 90);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   task automatic send_sample(input logic [lir_pkg::SAMPLE_W-1:0] s, input logic last);
      int gap;
      gap = 0;
      if (!calm_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{sample: s, last_in: last};
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic play_vector(input sample_list_type vals);
      foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
      vectors_sent++;
   endtask

   task automatic random_vector(input int len);
      for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
      vectors_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_out_count(input logic [lir_pkg::CNT_W-1:0] v);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm_tail) begin
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_linear_interp_resampler_core: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A single-sample vector under the reset setting clamps both neighbors to index 0.
      vec = '{16'h7FFF};
      play_vector(vec);
      set_out_count(7'd1);
      vec = '{16'h8000, 16'h7FFF, 16'h0000};
      play_vector(vec);
      set_out_count(7'd0);
      vec = '{16'hFFFF, 16'h0001};
      play_vector(vec);
      set_out_count(7'd127);
      vec = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA};
      play_vector(vec);
      set_out_count(7'd3);
      vec = '{16'h0000, 16'h0001};
      play_vector(vec);
      set_out_count(7'd7);
      vec = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFE, 16'h0002, 16'h0064, 16'hFF9C};
      play_vector(vec);

      target = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < target) begin
         if (requests_sent >= target - CALM_REQUESTS) calm_tail = 1'b1;
         if ($urandom_range(0, 3) == 0) set_out_count(pick_count());
         else if ($urandom_range(0, 9) == 0) drain_results();
         random_vector(pick_length());
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d vectors from %0d requests with %0d results checked,",
               vectors_sent, requests_sent, checked_count);
      $display("with out_count settings from 0 through 127 and stalls on both channels.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_linear_interp_resampler_core: clean");
      end else begin
         $display("tb_linear_interp_resampler_core: errors");
      end
      $finish;
   end

endmodule
